/* design/sparse_transpose_scatter_accumulate_assert.svh */
// assertion helpers used by the asserting file
`ifndef SPARSE_TRANSPOSE_SCATTER_ACCUMULATE_ASSERT_SVH
`define SPARSE_TRANSPOSE_SCATTER_ACCUMULATE_ASSERT_SVH

// same-cycle implication, sampled on the block clock outside reset
`define STSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stsa check failed");

// next-cycle implication
`define STSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stsa check failed");

`endif

/* design/stsa_pkg.sv */
package stsa_pkg;

    localparam int STSA_NUM_COLUMNS = 4096;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // one queued item, classified by the front end
    typedef struct packed {
        logic        action;
        logic [11:0] column;
        logic [31:0] value;
        logic [31:0] weight;
        logic        inrange;
    } t_item;

    typedef struct packed {
        logic [1:0] count;
    } t_front_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    localparam logic ACT_ACC  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    function automatic logic f_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // biased exponent, subnormals read as one
    function automatic logic [7:0] f_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    endfunction

    function automatic logic [23:0] f_man(input logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    // value = x * 2^(k-150); round to nearest even and pack
    function automatic logic [31:0] f_round_pack(input logic sign, input logic [49:0] x,
                                                 input logic signed [11:0] k);
        logic [5:0]         msb;
        logic signed [12:0] er;
        logic signed [12:0] s;
        logic signed [12:0] ks;
        logic [113:0]       y;
        logic [24:0]        m;
        logic               g;
        logic               st;
        logic [5:0]         rs;
        logic [5:0]         ls;
        msb = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (x[i]) msb = 6'(i);
        end
        ks = 13'(k);
        er = ks + $signed({7'b0, msb}) - 13'sd23;
        if (er < 13'sd1) er = 13'sd1;
        s = er - ks;
        y = '0;
        if (s <= 13'sd0) begin
            ls = 6'(-s);
            m  = 25'(x << ls);
            g  = 1'b0;
            st = 1'b0;
        end else begin
            rs = (s > 13'sd63) ? 6'd63 : 6'(s);
            y  = {x, 64'd0} >> rs;
            m  = {1'b0, y[87:64]};
            g  = y[63];
            st = |y[62:0];
        end
        if (g && (st || m[0])) m = m + 25'd1;
        if (m[24]) begin
            m  = m >> 1;
            er = er + 13'sd1;
        end
        if (x == 50'd0) return {sign, 31'd0};
        if (er >= 13'sd255) return {sign, 8'hFF, 23'd0};
        return {sign, m[23] ? er[7:0] : 8'h00, m[22:0]};
    endfunction

endpackage

/* design/sparse_transpose_scatter_accumulate.sv */
// accumulate beat: store written after states RD, MUL, PRD, ALN, ADD and RND, no result
// read beat: result valid after states RD and RDO (RDO waits for a free output), entry cleared at the same time
// the back-end sequencer takes a new beat only after it returns to idle from the last one
// a two-entry queue lets the input side run ahead of the sequencer
// reset (synchronous, active low) starts a clearing pass over all NUM_COLUMNS entries, input not ready
`include "sparse_transpose_scatter_accumulate_assert.svh"
module sparse_transpose_scatter_accumulate #(
    parameter int NUM_COLUMNS = stsa_pkg::STSA_NUM_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [11:0] i_column,
    input  logic [31:0] i_element_value,
    input  logic [31:0] i_row_weight,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_read_column,
    output logic [31:0] o_column_sum
);
    import stsa_pkg::*;

    localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int CW = AW + 12;

    t_item        head;
    logic         head_valid;
    logic         pop;
    t_front_stat  front_stat;
    t_back_stat   back_stat;
    logic [CW-1:0] out_col_wide;
    logic         out_oob;

    // input queue and classification
    stsa_front #(.NUM_COLUMNS(NUM_COLUMNS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_column        (i_column),
        .i_element_value (i_element_value),
        .i_row_weight    (i_row_weight),
        .i_back_stat     (back_stat),
        .i_pop           (pop),
        .o_head_valid    (head_valid),
        .o_head          (head),
        .o_stat          (front_stat)
    );

    // sequencer, float unit and column store
    stsa_back #(.NUM_COLUMNS(NUM_COLUMNS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_stat        (back_stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_column (o_read_column),
        .o_column_sum  (o_column_sum)
    );

    assign out_col_wide = {{AW{1'b0}}, o_read_column};
    assign out_oob      = out_col_wide >= CW'(NUM_COLUMNS);

    // checks
    `STSA_ASSERT_IMP(a_clear_blocks_input, back_stat.clearing, !o_in_ready)
    `STSA_ASSERT_IMP(a_queue_bound, 1'b1, front_stat.count != 2'd3)
    `STSA_ASSERT_IMP(a_oob_reads_zero, o_out_valid && out_oob, o_column_sum == 32'd0)
    `STSA_ASSERT_NXT(a_pop_when_full, pop && (front_stat.count == 2'd2) && !o_in_ready,
                     front_stat.count != 2'd2)

endmodule

/* design/stsa_front.sv */
module stsa_front #(
    parameter int NUM_COLUMNS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [11:0]          i_column,
    input  logic [31:0]          i_element_value,
    input  logic [31:0]          i_row_weight,
    input  stsa_pkg::t_back_stat i_back_stat,
    input  logic                 i_pop,
    output logic                 o_head_valid,
    output stsa_pkg::t_item      o_head,
    output stsa_pkg::t_front_stat o_stat
);
    import stsa_pkg::*;

    localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int CW = AW + 12;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;
    logic [CW-1:0] col_wide;
    t_item      item;

    // classify the incoming beat
    assign col_wide     = {{AW{1'b0}}, i_column};
    assign item.action  = i_action;
    assign item.column  = i_column;
    assign item.value   = i_element_value;
    assign item.weight  = i_row_weight;
    assign item.inrange = col_wide < CW'(NUM_COLUMNS);

    assign o_in_ready   = (r_cnt != 2'd2) && !i_back_stat.clearing;
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head_valid = r_cnt != 2'd0;
    assign o_head       = r_q[r_rp];
    assign o_stat.count = r_cnt;

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    // two-entry queue between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

endmodule

/* design/stsa_back.sv */
module stsa_back #(
    parameter int NUM_COLUMNS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  stsa_pkg::t_item      i_head,
    output logic                 o_pop,
    output stsa_pkg::t_back_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [11:0]          o_read_column,
    output logic [31:0]          o_column_sum
);
    import stsa_pkg::*;

    localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_RDO  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_PRD  = 4'd5;
    localparam logic [3:0] S_ALN  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_RND  = 4'd8;

    logic [31:0] mem [NUM_COLUMNS];
    logic [31:0] r_rdata;

    logic [3:0]  r_state, n_state;
    logic [AW-1:0] r_clr;
    t_item       r_item;
    logic [AW-1:0] r_addr;
    logic [AW+11:0] head_wide;

    // output register
    logic        r_ov;
    logic [11:0] r_ocol;
    logic [31:0] r_osum;

    // multiply stage
    logic [47:0]       r_p;
    logic signed [11:0] r_pk;
    logic              r_psign, r_pnan, r_pinf;
    logic [31:0]       r_prod;
    logic [31:0]       r_acc;

    // add stage
    logic [26:0]       r_a, r_b;
    logic              r_sub, r_asign, r_anan, r_ainf;
    logic [7:0]        r_eh;
    logic [27:0]       r_x;
    logic signed [11:0] r_xk;
    logic              r_xsign;
    logic [31:0]       sum_res;

    logic          we;
    logic [AW-1:0] wa;
    logic [31:0]   wd;
    logic          out_free;

    // alignment signals
    logic          a_big;
    logic [31:0]   fh, fl;
    logic [7:0]    dexp;
    logic [4:0]    dcap;
    logic [53:0]   bsh;

    assign head_wide   = {{AW{1'b0}}, i_head.column};
    assign out_free    = !r_ov || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && i_head_valid;
    assign o_stat.clearing = r_state == S_CLR;
    assign o_out_valid   = r_ov;
    assign o_read_column = r_ocol;
    assign o_column_sum  = r_osum;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AW'(NUM_COLUMNS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_head_valid) n_state = S_RD;
            S_RD:   n_state = (r_item.action == ACT_READ) ? S_RDO : S_MUL;
            S_RDO:  if (out_free) n_state = S_IDLE;
            S_MUL:  n_state = S_PRD;
            S_PRD:  n_state = S_ALN;
            S_ALN:  n_state = S_ADD;
            S_ADD:  n_state = S_RND;
            S_RND:  n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + AW'(1);
            if (r_state == S_RDO && out_free) r_ov <= 1'b1;
            else if (i_out_ready)             r_ov <= 1'b0;
        end
    end

    // item latch and read-out payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_addr <= head_wide[AW-1:0];
        end
        if (r_state == S_RDO && out_free) begin
            r_ocol <= r_item.column;
            r_osum <= r_item.inrange ? r_rdata : 32'd0;
        end
    end

    // memory write port select
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = 32'd0;
        priority if (r_state == S_CLR) begin
            we = 1'b1;
            wa = r_clr;
        end else if (r_state == S_RDO) begin
            we = out_free && r_item.inrange;
        end else if (r_state == S_RND) begin
            we = r_item.inrange;
            wd = sum_res;
        end else begin
            we = 1'b0;
        end
    end

    // column store
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[r_addr];
    end

    // mantissa product and special flags
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_acc   <= r_rdata;
            r_p     <= f_man(r_item.value) * f_man(r_item.weight);
            r_pk    <= $signed({4'b0, f_exp(r_item.value)}) + $signed({4'b0, f_exp(r_item.weight)})
                       - 12'sd150;
            r_psign <= r_item.value[31] ^ r_item.weight[31];
            r_pnan  <= f_is_nan(r_item.value) || f_is_nan(r_item.weight)
                       || (f_is_inf(r_item.value) && f_is_zero(r_item.weight))
                       || (f_is_inf(r_item.weight) && f_is_zero(r_item.value));
            r_pinf  <= f_is_inf(r_item.value) || f_is_inf(r_item.weight);
        end
    end

    // product rounded to single
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRD) begin
            priority if (r_pnan) r_prod <= CANON_NAN;
            else if (r_pinf)     r_prod <= {r_psign, 8'hFF, 23'd0};
            else                 r_prod <= f_round_pack(r_psign, {2'b0, r_p}, r_pk);
        end
    end

    // operand alignment
    always_comb begin
        a_big = r_acc[30:0] >= r_prod[30:0];
        fh    = a_big ? r_acc : r_prod;
        fl    = a_big ? r_prod : r_acc;
        dexp  = f_exp(fh) - f_exp(fl);
        dcap  = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
        bsh   = {f_man(fl), 3'b0, 27'd0} >> dcap;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ALN) begin
            r_a     <= {f_man(fh), 3'b0};
            r_b     <= {bsh[53:28], bsh[27] | (|bsh[26:0])};
            r_eh    <= f_exp(fh);
            r_sub   <= r_acc[31] ^ r_prod[31];
            r_asign <= fh[31];
            r_anan  <= f_is_nan(r_acc) || f_is_nan(r_prod)
                       || (f_is_inf(r_acc) && f_is_inf(r_prod) && (r_acc[31] != r_prod[31]));
            r_ainf  <= f_is_inf(r_acc) || f_is_inf(r_prod);
        end
    end

    // add or subtract aligned magnitudes
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_x     <= r_sub ? ({1'b0, r_a} - {1'b0, r_b}) : ({1'b0, r_a} + {1'b0, r_b});
            r_xk    <= $signed({4'b0, r_eh}) - 12'sd3;
            r_xsign <= (r_sub && (r_a == r_b)) ? 1'b0 : r_asign;
        end
    end

    // final rounding of the sum
    always_comb begin
        priority if (r_anan) sum_res = CANON_NAN;
        else if (r_ainf)     sum_res = {r_asign, 8'hFF, 23'd0};
        else                 sum_res = f_round_pack(r_xsign, {22'b0, r_x}, r_xk);
    end

endmodule
